[sv/humidity_frame_check_convert_macros.svh]
// Assertion macros for the humidity frame checker top level.
`ifndef HUMIDITY_FRAME_CHECK_CONVERT_MACROS_SVH
`define HUMIDITY_FRAME_CHECK_CONVERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HFCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hfcc assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define HFCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hfcc assertion failed: next-cycle implication");

`endif

[sv/hfcc_pkg.sv]
// Shared types, constants and the CRC-8 step for the humidity frame checker.
package hfcc_pkg;

  localparam logic [7:0]         CRC_POLY     = 8'h31;
  localparam logic [7:0]         CRC_INIT     = 8'hFF;
  localparam logic [15:0]        FULL_SCALE   = 16'hFFFF;
  localparam logic [15:0]        HALF_SCALE   = 16'd32767;
  localparam logic [10:0]        TEMP_SPAN    = 11'd1750;
  localparam logic [10:0]        HUMID_SPAN   = 11'd1000;
  localparam logic signed [11:0] TEMP_OFFSET  = -12'sd450;
  localparam logic [15:0]        FAIL_MAX     = 16'hFFFF;

  // Byte position within the six-byte reply
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5,
    POS_IDLE  = 3'd6
  } pos_t;

  // Frame tracker status for the byte at the head of the pipeline
  typedef struct packed {
    logic emit;  // byte closes a frame and yields a result
    logic ok;    // both checksums matched
  } frame_stat_t;

  // One byte of CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

[sv/hfcc_in_if.sv]
// Byte input channel: valid/ready handshake with reply byte and frame start.
interface hfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

[sv/hfcc_out_if.sv]
// Result channel: valid/ready handshake with checksum status and measurements.
interface hfcc_out_if;
  logic               valid;
  logic               ready;
  logic               crc_ok;
  logic               have_meas;
  logic signed [11:0] temp_tenths_c;
  logic [9:0]         humid_tenths_pct;
  logic [15:0]        crc_fail_total;

  modport source (output valid, output crc_ok, output have_meas, output temp_tenths_c,
                  output humid_tenths_pct, output crc_fail_total, input ready);
  modport sink   (input valid, input crc_ok, input have_meas, input temp_tenths_c,
                  input humid_tenths_pct, input crc_fail_total, output ready);
endinterface

[sv/hfcc_frame.sv]
// Frame tracker: byte position, running CRC-8 and captured raw words.
module hfcc_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  output hfcc_pkg::frame_stat_t stat,
  output logic [15:0]          temp_word,
  output logic [15:0]          humid_word
);

  hfcc_pkg::pos_t pos, pos_eff, pos_next;
  logic [7:0]     running_crc, crc_next, crc_eff, crc_step;
  logic [15:0]    temp_word_next, humid_word_next;
  logic           temp_crc_good, temp_crc_good_next;

  // A frame start overrides the current position
  assign pos_eff  = frame_start ? hfcc_pkg::POS_T_HI : pos;
  assign crc_eff  = frame_start ? hfcc_pkg::CRC_INIT : running_crc;
  assign crc_step = hfcc_pkg::crc_byte(crc_eff, rx_byte);

  // Next position
  always_comb begin
    unique case (pos_eff)
      hfcc_pkg::POS_T_HI:  pos_next = hfcc_pkg::POS_T_LO;
      hfcc_pkg::POS_T_LO:  pos_next = hfcc_pkg::POS_T_CRC;
      hfcc_pkg::POS_T_CRC: pos_next = hfcc_pkg::POS_H_HI;
      hfcc_pkg::POS_H_HI:  pos_next = hfcc_pkg::POS_H_LO;
      hfcc_pkg::POS_H_LO:  pos_next = hfcc_pkg::POS_H_CRC;
      hfcc_pkg::POS_H_CRC: pos_next = hfcc_pkg::POS_IDLE;
      default:             pos_next = hfcc_pkg::POS_IDLE;
    endcase
  end

  // Data path and status per position
  always_comb begin
    crc_next           = running_crc;
    temp_word_next     = temp_word;
    humid_word_next    = humid_word;
    temp_crc_good_next = temp_crc_good;
    stat.emit          = 1'b0;
    stat.ok            = 1'b0;
    unique case (pos_eff)
      hfcc_pkg::POS_T_HI: begin
        temp_word_next = {rx_byte, 8'h00};
        crc_next       = crc_step;
      end
      hfcc_pkg::POS_T_LO: begin
        temp_word_next = {temp_word[15:8], rx_byte};
        crc_next       = crc_step;
      end
      hfcc_pkg::POS_T_CRC: begin
        temp_crc_good_next = (crc_eff == rx_byte);
        crc_next           = hfcc_pkg::CRC_INIT;
      end
      hfcc_pkg::POS_H_HI: begin
        humid_word_next = {rx_byte, 8'h00};
        crc_next        = crc_step;
      end
      hfcc_pkg::POS_H_LO: begin
        humid_word_next = {humid_word[15:8], rx_byte};
        crc_next        = crc_step;
      end
      hfcc_pkg::POS_H_CRC: begin
        stat.emit = 1'b1;
        stat.ok   = temp_crc_good && (crc_eff == rx_byte);
        crc_next  = hfcc_pkg::CRC_INIT;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= hfcc_pkg::POS_IDLE;
      running_crc   <= hfcc_pkg::CRC_INIT;
      temp_crc_good <= 1'b0;
    end else if (step) begin
      pos           <= pos_next;
      running_crc   <= crc_next;
      temp_crc_good <= temp_crc_good_next;
    end
  end

  // Raw words, always written high byte first within a frame
  always_ff @(posedge clk) begin
    if (step) begin
      temp_word  <= temp_word_next;
      humid_word <= humid_word_next;
    end
  end

endmodule

[sv/hfcc_scale.sv]
// Raw-word scaling: temperature and humidity in tenths, rounded, over full scale.
module hfcc_scale (
  input  logic [15:0]        temp_word,
  input  logic [15:0]        humid_word,
  output logic signed [11:0] temp_tenths,
  output logic [9:0]         humid_tenths
);

  // Floor of x / 65535 for x below 2048 * 65536: quotient estimate from the
  // upper bits, remainder is low half plus estimate, one correction step.
  function automatic logic [10:0] div_full_scale(input logic [26:0] x);
    logic [10:0] q0;
    logic [16:0] r;
    q0 = x[26:16];
    r  = {1'b0, x[15:0]} + {6'd0, q0};
    return (r >= {1'b0, hfcc_pkg::FULL_SCALE}) ? q0 + 11'd1 : q0;
  endfunction

  logic [26:0] temp_prod, humid_prod;
  logic [10:0] temp_q, humid_q;

  // Scaled value plus half scale for round-to-nearest
  assign temp_prod  = 27'(temp_word) * 27'(hfcc_pkg::TEMP_SPAN)
                    + 27'(hfcc_pkg::HALF_SCALE);
  assign humid_prod = 27'(humid_word) * 27'(hfcc_pkg::HUMID_SPAN)
                    + 27'(hfcc_pkg::HALF_SCALE);

  assign temp_q  = div_full_scale(temp_prod);
  assign humid_q = div_full_scale(humid_prod);

  // Offset temperature; quotient stays within 0..1750
  assign temp_tenths  = $signed({1'b0, temp_q} + $unsigned(hfcc_pkg::TEMP_OFFSET));
  assign humid_tenths = humid_q[9:0];

endmodule

[sv/humidity_frame_check_convert.sv]
// Humidity frame checker top level: checks six-byte sensor replies and converts.
//
// rx carries one reply byte per transfer; frame_start marks the first byte of a
// frame (temperature high, low, CRC, humidity high, low, CRC). CRC-8 is poly
// 0x31, init 0xFF. Bytes outside an open frame are dropped silently.
// result carries one item per completed frame, on the sixth byte: crc_ok,
// have_meas, last good temperature and humidity in tenths, and the saturating
// CRC-fail count. A good frame updates the stored values; a bad one keeps them.
// A byte is first held in an input register; the result register then loads
// from the sixth byte held there. Throughput is one byte per cycle unless a
// sixth byte waits for the result register, set by the combinational CRC step
// and scaling between the two registers.
// When result is stalled, bytes that yield no result still flow; a sixth byte
// waits in the input register until the result register frees, and rx.ready
// drops only then. Reset clears the frame position (no frame open), the CRC,
// the stored measurement flag, stored values and the fail counter.
module humidity_frame_check_convert (
  input logic        clk,
  input logic        rst,
  hfcc_in_if.sink    rx,
  hfcc_out_if.source result
);

  `include "humidity_frame_check_convert_macros.svh"

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_start;
  logic                  advance, out_free, emit;
  hfcc_pkg::frame_stat_t stat;
  logic [15:0]           temp_word, humid_word;
  logic signed [11:0]    temp_conv;
  logic [9:0]            humid_conv;

  logic                  meas_valid, meas_valid_next;
  logic signed [11:0]    stored_temp, stored_temp_next;
  logic [9:0]            stored_humid, stored_humid_next;
  logic [15:0]           fail_counter, fail_counter_next;

  // Handshake
  assign out_free = !result.valid || result.ready;
  assign emit     = s1_valid && stat.emit;
  assign advance  = s1_valid && (!stat.emit || out_free);
  assign rx.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte  <= rx.rx_byte;
      s1_start <= rx.frame_start;
    end
  end

  hfcc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .rx_byte     (s1_byte),
    .frame_start (s1_start),
    .stat        (stat),
    .temp_word   (temp_word),
    .humid_word  (humid_word)
  );

  hfcc_scale u_scale (
    .temp_word    (temp_word),
    .humid_word   (humid_word),
    .temp_tenths  (temp_conv),
    .humid_tenths (humid_conv)
  );

  // Stored measurement and fail count update at frame end
  always_comb begin
    meas_valid_next   = meas_valid;
    stored_temp_next  = stored_temp;
    stored_humid_next = stored_humid;
    fail_counter_next = fail_counter;
    if (stat.ok) begin
      meas_valid_next   = 1'b1;
      stored_temp_next  = temp_conv;
      stored_humid_next = humid_conv;
    end else if (fail_counter != hfcc_pkg::FAIL_MAX) begin
      fail_counter_next = fail_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid   <= 1'b0;
      stored_temp  <= '0;
      stored_humid <= '0;
      fail_counter <= '0;
    end else if (advance && emit) begin
      meas_valid   <= meas_valid_next;
      stored_temp  <= stored_temp_next;
      stored_humid <= stored_humid_next;
      fail_counter <= fail_counter_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result.crc_ok           <= stat.ok;
      result.have_meas        <= meas_valid_next;
      result.temp_tenths_c    <= stored_temp_next;
      result.humid_tenths_pct <= stored_humid_next;
      result.crc_fail_total   <= fail_counter_next;
    end
  end

  // Checks
  `HFCC_ASSERT_NEXT(a_fail_monotonic, clk, rst, 1'b1, fail_counter >= $past(fail_counter))
  `HFCC_ASSERT_NEXT(a_emit_loads, clk, rst, advance && emit, result.valid)
  `HFCC_ASSERT_IMPLY(a_have_meas_stored, clk, rst, result.valid && result.have_meas, meas_valid)
  `HFCC_ASSERT_IMPLY(a_ok_has_meas, clk, rst, result.valid && result.crc_ok, result.have_meas)

endmodule

[tb/sv/tb_humidity_frame_check_convert.sv]
// Self-checking testbench for the six-byte humidity frame checker and converter.
`timescale 1ns / 1ps

module tb_humidity_frame_check_convert;

  // Scaling constants for the measurement conversion
  localparam int unsigned TEMP_SPAN_T   = 1750;
  localparam int unsigned HUMID_SPAN_T  = 1000;
  localparam int unsigned RAW_FULL      = 65535;
  localparam int unsigned TEMP_OFFSET_T = 450;

  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_CALM    = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTED  = 30;
  localparam longint TIMEOUT_NS = 64'd2_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } reply_byte_t;

  typedef struct packed {
    logic              crc_ok;
    logic              have_meas;
    logic signed [11:0] temp;
    logic [9:0]        humid;
    logic [15:0]       fails;
  } frame_report_t;

  logic clk;
  logic rst;

  hfcc_in_if  rx_if ();
  hfcc_out_if res_if ();

  humidity_frame_check_convert u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if)
  );

  // Stimulus and expectation stores
  reply_byte_t   reply_bytes[$];
  frame_report_t expected_frames[$];
  int            calm_mark;
  int            mismatches;
  int            bytes_total;
  int            bytes_accepted;
  int            frames_seen;

  // Predictor state
  hfcc_pkg::pos_t     frame_pos;
  logic [7:0]         crc_acc;
  logic [15:0]        t_raw;
  logic [15:0]        h_raw;
  logic               t_crc_ok;
  logic signed [11:0] last_temp;
  logic [9:0]         last_humid;
  logic               meas_seen;
  logic [15:0]        fail_count;

  // Handshake pacing
  int            gap_left;
  int            gap_pct;
  int            stall_left;
  int            stall_pct;
  reply_byte_t   next_byte;
  frame_report_t want;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-8, poly 0x31, MSB first, one input bit at a time
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? hfcc_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_update(crc8_update(hfcc_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Raw sensor word, leaning toward the ends of the range
  function automatic logic [15:0] sensor_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Nonzero damage for one or both checksum bytes: {temp flip, humid flip}
  function automatic logic [15:0] crc_damage();
    case ($urandom_range(0, 2))
      0: return {8'($urandom_range(1, 255)), 8'h00};
      1: return {8'h00, 8'($urandom_range(1, 255))};
      default: return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endcase
  endfunction

  function automatic bit in_tail();
    return reply_bytes.size() <= calm_mark;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic start);
    reply_byte_t rb;
    rb.data  = data;
    rb.start = start;
    reply_bytes.push_back(rb);
  endtask

  // Push the first keep bytes of a reply frame, checksums XORed with the flips
  task automatic queue_frame(input logic [15:0] tw, input logic [15:0] hw,
                             input logic [15:0] flips, input int keep);
    logic [7:0] seq[6];
    seq[0] = tw[15:8];
    seq[1] = tw[7:0];
    seq[2] = word_crc(tw) ^ flips[15:8];
    seq[3] = hw[15:8];
    seq[4] = hw[7:0];
    seq[5] = word_crc(hw) ^ flips[7:0];
    for (int i = 0; i < keep; i++) queue_byte(seq[i], i == 0);
  endtask

  // Predictor: one accepted byte, pushes a report on the sixth byte of a frame
  task automatic decode_byte(input logic [7:0] b, input logic start);
    frame_report_t rep;
    int unsigned   tq;
    int unsigned   hq;
    if (start) begin
      frame_pos = hfcc_pkg::POS_T_HI;
      crc_acc   = hfcc_pkg::CRC_INIT;
    end else if (frame_pos == hfcc_pkg::POS_IDLE) begin
      return;
    end
    case (frame_pos)
      hfcc_pkg::POS_T_HI: begin
        t_raw[15:8] = b;
        crc_acc     = crc8_update(crc_acc, b);
        frame_pos   = hfcc_pkg::POS_T_LO;
      end
      hfcc_pkg::POS_T_LO: begin
        t_raw[7:0] = b;
        crc_acc    = crc8_update(crc_acc, b);
        frame_pos  = hfcc_pkg::POS_T_CRC;
      end
      hfcc_pkg::POS_T_CRC: begin
        t_crc_ok  = (crc_acc == b);
        crc_acc   = hfcc_pkg::CRC_INIT;
        frame_pos = hfcc_pkg::POS_H_HI;
      end
      hfcc_pkg::POS_H_HI: begin
        h_raw[15:8] = b;
        crc_acc     = crc8_update(crc_acc, b);
        frame_pos   = hfcc_pkg::POS_H_LO;
      end
      hfcc_pkg::POS_H_LO: begin
        h_raw[7:0] = b;
        crc_acc    = crc8_update(crc_acc, b);
        frame_pos  = hfcc_pkg::POS_H_CRC;
      end
      default: begin
        // sixth byte: verdict, conversion or fail count
        rep.crc_ok = t_crc_ok && (crc_acc == b);
        if (rep.crc_ok) begin
          tq         = (TEMP_SPAN_T * t_raw + RAW_FULL / 2) / RAW_FULL;
          hq         = (HUMID_SPAN_T * h_raw + RAW_FULL / 2) / RAW_FULL;
          last_temp  = 12'(tq - TEMP_OFFSET_T);
          last_humid = 10'(hq);
          meas_seen  = 1'b1;
        end else if (fail_count != hfcc_pkg::FAIL_MAX) begin
          fail_count = fail_count + 16'd1;
        end
        crc_acc       = hfcc_pkg::CRC_INIT;
        frame_pos     = hfcc_pkg::POS_IDLE;
        rep.have_meas = meas_seen;
        rep.temp      = last_temp;
        rep.humid     = last_humid;
        rep.fails     = fail_count;
        expected_frames.push_back(rep);
      end
    endcase
  endtask

  // Byte driver: feeds reply_bytes, idles in bursts outside the tail
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        decode_byte(rx_if.rx_byte, rx_if.frame_start);
        bytes_accepted++;
        if ($urandom_range(0, 99) == 0) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 40;
          endcase
        end
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left > 0 || reply_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          rx_if.valid       <= 1'b0;
          rx_if.rx_byte     <= 8'($urandom);
          rx_if.frame_start <= 1'($urandom_range(0, 1));
        end else if (!in_tail() && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 7);
          rx_if.valid       <= 1'b0;
          rx_if.rx_byte     <= 8'($urandom);
          rx_if.frame_start <= 1'($urandom_range(0, 1));
        end else begin
          next_byte = reply_bytes.pop_front();
          rx_if.valid       <= 1'b1;
          rx_if.rx_byte     <= next_byte.data;
          rx_if.frame_start <= next_byte.start;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        frames_seen++;
        if (expected_frames.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", frames_seen));
        end else begin
          want = expected_frames.pop_front();
          if (res_if.crc_ok !== want.crc_ok)
            note_mismatch($sformatf("result %0d crc_ok got %b want %b",
                                    frames_seen, res_if.crc_ok, want.crc_ok));
          if (res_if.have_meas !== want.have_meas)
            note_mismatch($sformatf("result %0d have_meas got %b want %b",
                                    frames_seen, res_if.have_meas, want.have_meas));
          if (res_if.temp_tenths_c !== want.temp)
            note_mismatch($sformatf("result %0d temp_tenths_c got %0d want %0d",
                                    frames_seen, res_if.temp_tenths_c, want.temp));
          if (res_if.humid_tenths_pct !== want.humid)
            note_mismatch($sformatf("result %0d humid_tenths_pct got %0d want %0d",
                                    frames_seen, res_if.humid_tenths_pct, want.humid));
          if (res_if.crc_fail_total !== want.fails)
            note_mismatch($sformatf("result %0d crc_fail_total got %0d want %0d",
                                    frames_seen, res_if.crc_fail_total, want.fails));
        end
      end
      // back-pressure in bursts, none in the tail
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 15;
            default: stall_pct = 50;
          endcase
        end
        res_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus build, reset, end of run
  initial begin
    int          counted;
    int          pick;
    logic [15:0] flips;

    rst               = 1'b1;
    rx_if.valid       = 1'b0;
    rx_if.rx_byte     = 8'h00;
    rx_if.frame_start = 1'b0;
    res_if.ready      = 1'b0;
    mismatches        = 0;
    bytes_accepted    = 0;
    frames_seen       = 0;
    gap_left          = 0;
    gap_pct           = 10;
    stall_left        = 0;
    stall_pct         = 15;
    calm_mark         = 0;

    frame_pos  = hfcc_pkg::POS_IDLE;
    crc_acc    = hfcc_pkg::CRC_INIT;
    t_raw      = 16'h0000;
    h_raw      = 16'h0000;
    t_crc_ok   = 1'b0;
    last_temp  = 12'sd0;
    last_humid = 10'd0;
    meas_seen  = 1'b0;
    fail_count = 16'h0000;

    // Directed: stray byte while idle after reset
    queue_byte(8'hAA, 1'b0);
    // bad temperature checksum before any good frame: zeros, no measurement
    queue_frame(16'hBEEF, 16'h6666, 16'h0100, 6);
    // restart mid-frame, then good frame at temp minimum and humidity maximum
    queue_frame(16'h1234, 16'h5678, 16'h0000, 2);
    queue_frame(16'h0000, 16'hFFFF, 16'h0000, 6);
    // byte after the sixth is dropped
    queue_byte(8'h55, 1'b0);
    // temp maximum and humidity minimum
    queue_frame(16'hFFFF, 16'h0000, 16'h0000, 6);
    // bad humidity checksum keeps the stored values
    queue_frame(16'h8000, 16'h7FFF, 16'h0080, 6);

    // Random: mostly whole frames, some truncated frames and noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 99);
      flips = ($urandom_range(0, 3) == 0) ? crc_damage() : 16'h0000;
      if (pick < 70) begin
        queue_frame(sensor_word(), sensor_word(), flips, 6);
        counted += 6;
      end else if (pick < 80) begin
        pick = $urandom_range(1, 5);
        queue_frame(sensor_word(), sensor_word(), flips, pick);
        counted += pick;
      end else if (pick < 90) begin
        pick = $urandom_range(1, 3);
        repeat (pick) queue_byte(8'($urandom), 1'b0);
        counted += pick;
      end else begin
        queue_byte(8'($urandom), 1'($urandom_range(0, 1)));
        counted += 1;
      end
    end

    // Closing frames, good and bad, in the calm tail
    queue_frame(sensor_word(), sensor_word(), 16'h0000, 6);
    queue_frame(sensor_word(), sensor_word(), crc_damage(), 6);
    queue_frame(sensor_word(), sensor_word(), crc_damage(), 6);
    queue_frame(sensor_word(), sensor_word(), 16'h0000, 6);
    calm_mark   = TAIL_CALM;
    bytes_total = reply_bytes.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait for every byte to transfer and every report to come back
    while (bytes_accepted < bytes_total || expected_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/hfcc_pkg.sv
sv/hfcc_in_if.sv
sv/hfcc_out_if.sv
sv/hfcc_frame.sv
sv/hfcc_scale.sv
sv/humidity_frame_check_convert.sv
tb/sv/tb_humidity_frame_check_convert.sv
